FILE: design/mrrc_pkg.sv
// ----------------------------------------------------------------------------
// mrrc_pkg
// Shared types, codes and the CRC-16 byte update for the read-response checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mrrc_pkg;

   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'hA001;
   localparam logic [7:0]  FUNC_READ_HOLD = 8'h03;
   localparam logic [7:0]  MAX_DATA_BYTES = 8'd250;
   localparam logic [8:0]  FRAME_OVERHEAD = 9'd5;
   localparam logic [8:0]  POS_MAX        = 9'd511;

   // status codes
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_SHORT = 3'd1;
   localparam logic [2:0] ST_CRC   = 3'd2;
   localparam logic [2:0] ST_FUNC  = 3'd3;
   localparam logic [2:0] ST_COUNT = 3'd4;

   // operation codes (req_tuser)
   localparam logic OP_RX_BYTE  = 1'b0;
   localparam logic OP_READ_REG = 1'b1;

   // result kinds (rsp_tuser)
   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   // staged word write into the spare bank
   typedef struct packed {
      logic        we;
      logic [7:0]  slot;
      logic [15:0] data;
   } wr_req_type;

   // end-of-frame verdict
   typedef struct packed {
      logic        done;
      logic        ok;
      logic [2:0]  status;
      logic [6:0]  words;
   } frame_res_type;

   // reflected CRC-16, one byte, LSB first
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: design/mrrc_frame.sv
// ----------------------------------------------------------------------------
// mrrc_frame
// Per-byte frame tracking: CRC, position, header capture, word assembly and
// the end-of-frame check.
// ----------------------------------------------------------------------------
`default_nettype none

module mrrc_frame #(
   parameter int REG_SLOTS = 128
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      commit,
   input  wire  [7:0]               rx_byte,
   input  wire                      frame_end,
   output mrrc_pkg::wr_req_type     wr,
   output mrrc_pkg::frame_res_type  res
);
   import mrrc_pkg::*;

   localparam logic [8:0] SLOTS9 = 9'(REG_SLOTS);
   localparam logic [7:0] SLOTS8 = 8'(REG_SLOTS);

   logic [15:0] crc_ff, crc_in;
   logic [8:0]  pos_ff, pos_in;
   logic [7:0]  func_ff, func_in;
   logic [7:0]  bc_ff, bc_in;
   logic [7:0]  hold_ff, hold_in;
   logic [8:0]  data_pos;
   logic [6:0]  words;

   assign crc_in   = crc16_byte(crc_ff, rx_byte);
   assign pos_in   = (pos_ff == POS_MAX) ? POS_MAX : pos_ff + 9'd1;
   assign data_pos = pos_ff - 9'd3;

   always_comb begin
      func_in = func_ff;
      bc_in   = bc_ff;
      hold_in = hold_ff;
      wr.we   = 1'b0;
      wr.slot = data_pos[8:1];
      wr.data = {hold_ff, rx_byte};
      if (pos_ff == 9'd1) begin
         func_in = rx_byte;
      end else if (pos_ff == 9'd2) begin
         bc_in = rx_byte;
      end else if (pos_ff >= 9'd3) begin
         if (!data_pos[0]) begin
            hold_in = rx_byte;
         end else if ({1'b0, data_pos[8:1]} < SLOTS9) begin
            wr.we = commit;
         end
      end
   end

   // words capped to the store depth; byte count is not bounded here, the verdict checks it against 250
   always_comb begin
      words = bc_in[7:1];
      if ({1'b0, words} > SLOTS8) begin
         words = SLOTS8[6:0];
      end
   end

   always_comb begin
      res.done   = commit && frame_end;
      res.status = ST_OK;
      if (pos_in < FRAME_OVERHEAD) begin
         res.status = ST_SHORT;
      end else if (crc_in != 16'h0000) begin
         res.status = ST_CRC;
      end else if (func_in != FUNC_READ_HOLD) begin
         res.status = ST_FUNC;
      end else if (bc_in > MAX_DATA_BYTES || bc_in[0] ||
                   {1'b0, bc_in} != pos_in - FRAME_OVERHEAD) begin
         res.status = ST_COUNT;
      end
      res.ok    = (res.status == ST_OK);
      res.words = res.ok ? words : 7'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= CRC_INIT;
         pos_ff  <= 9'd0;
         func_ff <= 8'd0;
         bc_ff   <= 8'd0;
         hold_ff <= 8'd0;
      end else if (commit) begin
         if (frame_end) begin
            crc_ff  <= CRC_INIT;
            pos_ff  <= 9'd0;
            func_ff <= 8'd0;
            bc_ff   <= 8'd0;
            hold_ff <= 8'd0;
         end else begin
            crc_ff  <= crc_in;
            pos_ff  <= pos_in;
            func_ff <= func_in;
            bc_ff   <= bc_in;
            hold_ff <= hold_in;
         end
      end
   end

endmodule

`default_nettype wire

FILE: design/mrrc_store.sv
// ----------------------------------------------------------------------------
// mrrc_store
// Two-bank register word store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mrrc_store #(
   parameter int REG_SLOTS = 128
) (
   input  wire                   clock,
   input  mrrc_pkg::wr_req_type  wr,
   input  wire                   wr_bank,
   input  wire                   rd_en,
   input  wire                   rd_bank,
   input  wire  [6:0]            rd_idx,
   output logic [15:0]           rd_data_ff
);
   import mrrc_pkg::*;

   localparam int DEPTH  = 2 * REG_SLOTS;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [15:0]       mem [DEPTH];
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   assign wr_addr = wr_bank ? ADDR_W'(REG_SLOTS) + ADDR_W'(wr.slot) : ADDR_W'(wr.slot);
   assign rd_addr = rd_bank ? ADDR_W'(REG_SLOTS) + ADDR_W'(rd_idx) : ADDR_W'(rd_idx);

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[wr_addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: design/modbus_read_response_checker_unit.sv
// ----------------------------------------------------------------------------
// modbus_read_response_checker_unit
// Checks Modbus RTU read-holding-registers responses and serves the words.
// ----------------------------------------------------------------------------
// Usage:
//  req channel: tuser selects the transaction (0 = frame byte, 1 = word read),
//    tdata[7:0] is the frame byte, tdata[14:8] the word index, tlast marks
//    the last byte of a frame.
//  rsp channel: tuser is the result kind (0 = frame status, 1 = word read).
//    A frame byte without tlast gives no result; the last byte gives one
//    status result; each read gives one read result.
//  rsp_tvalid rises when the result register is loaded: the input register
//  is loaded at acceptance, the frame logic (CRC update, header capture,
//  store access) works from it, and the result register is loaded from it.
//  One transaction per cycle is sustained while results are taken; the
//  store's single write and single read port are never needed in the same
//  cycle. Reset clears the frame state and leaves no words readable. When
//  rsp_tready is low the result register holds; frame bytes without a
//  result keep moving, and req_tready drops once the input register holds
//  a transaction whose result cannot be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_read_response_checker_unit #(
   parameter int REG_SLOTS = 128
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // rx_byte[7:0], reg_index[14:8], zero pad
   input  wire         req_tlast,   // frame_end
   input  wire         req_tuser,   // operation
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // status[2:0], word_count[9:3], reg_value[25:10], zero pad
   output logic        rsp_tuser    // kind
);
   import mrrc_pkg::*;

   localparam int CNT_W = $clog2(REG_SLOTS + 1);

   // input register
   logic        s1_valid_ff;
   logic        s1_op_ff;
   logic [7:0]  s1_byte_ff;
   logic        s1_fend_ff;
   logic [6:0]  s1_idx_ff;

   // result register
   logic        out_valid_ff;
   logic        out_kind_ff;
   logic [2:0]  out_status_ff;
   logic [6:0]  out_words_ff;
   logic        out_hit_ff;

   logic             live_bank_ff, live_bank_in;
   logic [CNT_W-1:0] live_count_ff, live_count_in;

   logic          out_free, s1_has_rsp, s1_adv, req_fire;
   logic          byte_commit, rd_hit;
   wr_req_type    wr;
   frame_res_type res;
   logic [15:0]   rd_data;
   logic [15:0]   reg_value;

   assign out_free    = !out_valid_ff || rsp_tready;
   assign s1_has_rsp  = (s1_op_ff == OP_READ_REG) || s1_fend_ff;
   assign s1_adv      = s1_valid_ff && (!s1_has_rsp || out_free);
   assign req_tready  = !s1_valid_ff || s1_adv;
   assign req_fire    = req_tvalid && req_tready;
   assign byte_commit = s1_adv && (s1_op_ff == OP_RX_BYTE);
   assign rd_hit      = (s1_op_ff == OP_READ_REG) && ({1'b0, s1_idx_ff} < 8'(live_count_ff));

   mrrc_frame #(.REG_SLOTS(REG_SLOTS)) u_frame (
      .clock     (clock),
      .reset     (reset),
      .commit    (byte_commit),
      .rx_byte   (s1_byte_ff),
      .frame_end (s1_fend_ff),
      .wr        (wr),
      .res       (res)
   );

   mrrc_store #(.REG_SLOTS(REG_SLOTS)) u_store (
      .clock      (clock),
      .wr         (wr),
      .wr_bank    (!live_bank_ff),
      .rd_en      (s1_adv && rd_hit),
      .rd_bank    (live_bank_ff),
      .rd_idx     (s1_idx_ff),
      .rd_data_ff (rd_data)
   );

   always_comb begin
      live_bank_in  = live_bank_ff;
      live_count_in = live_count_ff;
      if (res.done && res.ok) begin
         live_bank_in  = !live_bank_ff;
         live_count_in = CNT_W'(res.words);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         live_bank_ff  <= 1'b0;
         live_count_ff <= '0;
      end else begin
         live_bank_ff  <= live_bank_in;
         live_count_ff <= live_count_in;
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s1_adv && s1_has_rsp) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff   <= req_tuser;
         s1_byte_ff <= req_tdata[7:0];
         s1_fend_ff <= req_tlast;
         s1_idx_ff  <= req_tdata[14:8];
      end
      if (s1_adv && s1_has_rsp) begin
         out_kind_ff   <= (s1_op_ff == OP_READ_REG) ? KIND_READ : KIND_STATUS;
         out_status_ff <= (s1_op_ff == OP_READ_REG) ? ST_OK : res.status;
         out_words_ff  <= (s1_op_ff == OP_READ_REG) ? 7'd0 : res.words;
         out_hit_ff    <= rd_hit;
      end
   end

   assign reg_value  = out_hit_ff ? rd_data : 16'h0000;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {6'd0, reg_value, out_words_ff, out_status_ff};

   // live word count never exceeds the store depth
   assert property (@(posedge clock) disable iff (reset)
      live_count_ff <= CNT_W'(REG_SLOTS))
      else $error("live word count beyond store depth");

   // banks swap only together with an ok status result
   assert property (@(posedge clock) disable iff (reset)
      (live_bank_ff != $past(live_bank_ff)) |->
         (out_valid_ff && out_kind_ff == KIND_STATUS && out_status_ff == ST_OK))
      else $error("bank swap without ok frame");

   // read results carry no status and no word count
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == KIND_READ) |->
         (out_status_ff == ST_OK && out_words_ff == 7'd0))
      else $error("read result with status fields");

   // failed frames report no words and read nothing from the store
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff != ST_OK) |->
         (out_words_ff == 7'd0 && !out_hit_ff))
      else $error("failed frame with words");

endmodule

`default_nettype wire
